/* rtl/interrupt_vector_allocator_macros.svh */
// Assertion macros for the interrupt vector allocator.
// Used by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define IVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define IVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/iva_pkg.sv */
// Shared types and constants for the interrupt vector allocator.
// No dependencies.
`default_nettype none

package iva_pkg;

    localparam int DEF_VECTOR_BASE  = 32;
    localparam int DEF_VECTOR_LIMIT = 256;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_CLAIM    = 3'd1;
    localparam logic [2:0] CMD_FREE     = 3'd2;
    localparam logic [2:0] CMD_ATTACH   = 3'd3;
    localparam logic [2:0] CMD_DETACH   = 3'd4;
    localparam logic [2:0] CMD_DISPATCH = 3'd5;

    localparam logic [3:0] ST_OK              = 4'd0;
    localparam logic [3:0] ST_NONE_FREE       = 4'd1;
    localparam logic [3:0] ST_RANGE           = 4'd2;
    localparam logic [3:0] ST_CLAIMED         = 4'd3;
    localparam logic [3:0] ST_DOUBLE_FREE     = 4'd4;
    localparam logic [3:0] ST_NOT_ALLOC       = 4'd5;
    localparam logic [3:0] ST_HANDLER_PRESENT = 4'd6;
    localparam logic [3:0] ST_NULL_HANDLER    = 4'd7;
    localparam logic [3:0] ST_DISP_UNALLOC    = 4'd8;
    localparam logic [3:0] ST_DISP_NO_HANDLER = 4'd9;

    typedef struct packed {
        logic [63:0] argument_word;
        logic [63:0] handler_word;
        logic [7:0]  vector;
        logic [2:0]  cmd;
    } item_t;

    typedef struct packed {
        logic [63:0] argument_out;
        logic [63:0] handler_out;
        logic        fire;
        logic [7:0]  vector_out;
        logic [3:0]  status;
    } result_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = 144;

    typedef struct packed {
        logic load;
        logic search_step;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic search_last;
    } ctl_sts_t;

endpackage

`default_nettype wire

/* rtl/interrupt_vector_allocator.sv */
// Top level of the interrupt vector allocator: stream ports, sequencer, datapath.
// Depends on iva_pkg, iva_ctrl, iva_datapath and interrupt_vector_allocator_macros.svh.
`default_nettype none

// One command per transaction, one result per command. Claim, free, attach,
// detach and dispatch pass from acceptance through a read state and an execute
// state that writes the result register. Alloc adds a search state for the
// next-fit scan of the allocation bitmap at 32 slots per cycle, over the
// default 224-vector window W. A new command is taken once the previous result
// is in the output register; an unread result holds the next one back until it
// drains. Handler and argument words live in single-port memories; per-vector
// allocation and handler-present bits are flip-flops cleared by reset, so no
// clearing pass is needed after reset.
`include "interrupt_vector_allocator_macros.svh"

module interrupt_vector_allocator
#(
    parameter int VECTOR_BASE  = iva_pkg::DEF_VECTOR_BASE,
    parameter int VECTOR_LIMIT = iva_pkg::DEF_VECTOR_LIMIT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cmd[2:0], vector[10:3], handler_word[74:11], argument_word[138:75], zero fill
    input  wire logic [iva_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[3:0], vector_out[11:4], fire[12], handler_out[76:13],
    // argument_out[140:77], zero fill
    output logic      [iva_pkg::TDATA_W-1:0]   m_tdata
);

    iva_pkg::item_t    item;
    iva_pkg::result_t  res;
    iva_pkg::ctl_cmd_t ctl;
    iva_pkg::ctl_sts_t sts;

    assign item    = iva_pkg::item_t'(s_tdata[iva_pkg::ITEM_W-1:0]);
    assign m_tdata = iva_pkg::TDATA_W'(res);

    iva_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    iva_datapath
    #(
        .VECTOR_BASE  (VECTOR_BASE),
        .VECTOR_LIMIT (VECTOR_LIMIT)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .ctl   (ctl),
        .sts   (sts),
        .res   (res)
    );

    `IVA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted twice")
    `IVA_ASSERT_SAME(a_exec_slot_free, clk, rst_n, ctl.exec, !m_tvalid || m_tready, "result overwritten")
    `IVA_ASSERT_NEXT(a_exec_shows, clk, rst_n, ctl.exec, m_tvalid, "result not presented")
    `IVA_ASSERT_SAME(a_fire_ok, clk, rst_n, m_tvalid && m_tdata[12], m_tdata[3:0] == iva_pkg::ST_OK, "fire with error")

endmodule

`default_nettype wire

/* rtl/iva_ctrl.sv */
// Command sequencer for the interrupt vector allocator.
// Depends on iva_pkg.
`default_nettype none

module iva_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output iva_pkg::ctl_cmd_t      ctl,
    input  wire iva_pkg::ctl_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_EXEC   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        ctl.load        = 1'b0;
        ctl.search_step = 1'b0;
        ctl.exec        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = sts.is_alloc ? S_SEARCH : S_EXEC;
            end
            S_SEARCH:
            begin
                ctl.search_step = 1'b1;
                if (sts.search_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.exec)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* rtl/iva_datapath.sv */
// Datapath: allocation bitmap, handler/argument memories, next-fit scan, result register.
// Depends on iva_pkg.
`default_nettype none

module iva_datapath
#(
    parameter int VECTOR_BASE  = iva_pkg::DEF_VECTOR_BASE,
    parameter int VECTOR_LIMIT = iva_pkg::DEF_VECTOR_LIMIT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iva_pkg::item_t    item,
    input  wire iva_pkg::ctl_cmd_t ctl,
    output iva_pkg::ctl_sts_t      sts,
    output iva_pkg::result_t       res
);

    localparam int TOP    = (VECTOR_LIMIT > 256) ? 256 : VECTOR_LIMIT;
    localparam int WIN    = (TOP > VECTOR_BASE) ? (TOP - VECTOR_BASE) : 0;
    localparam int DEPTH  = (WIN > 0) ? WIN : 1;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCHUNK = (DEPTH + 31) / 32;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W  = CH_W + 5;
    localparam int PAD    = NCHUNK * 32;
    localparam logic [8:0] WIN_LO = 9'(VECTOR_BASE);
    localparam logic [8:0] WIN_HI = 9'(VECTOR_BASE + WIN);
    localparam logic [CH_W-1:0] LAST_CHUNK = CH_W'(NCHUNK - 1);

    // latched command
    logic [2:0]        cmd_reg;
    logic [7:0]        vec_reg;
    logic [63:0]       hw_reg;
    logic [63:0]       aw_reg;
    logic              in_win_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic              in_win;
    logic [8:0]        v_off;

    // state
    logic [DEPTH-1:0]  alloc_map_reg;
    logic [DEPTH-1:0]  alloc_map_next;
    logic [DEPTH-1:0]  hnz_reg;
    logic [DEPTH-1:0]  hnz_next;
    logic [SLOT_W-1:0] hint_reg;
    logic [SLOT_W-1:0] hint_next;

    logic [63:0]       handler_mem [DEPTH];
    logic [63:0]       argument_mem [DEPTH];
    logic [63:0]       rd_h_reg;
    logic [63:0]       rd_a_reg;
    logic              mem_we;

    // scan
    logic [CH_W-1:0]   chunk_reg;
    logic              f1_reg;
    logic              f2_reg;
    logic [PAD_W-1:0]  i1_reg;
    logic [PAD_W-1:0]  i2_reg;
    logic [PAD-1:0]    free_pad;
    logic [31:0]       chunk_bits;
    logic [31:0]       m1;
    logic [31:0]       m2;
    logic [31:0]       low1;
    logic [31:0]       low2;
    logic [4:0]        e1;
    logic [4:0]        e2;

    iva_pkg::result_t  res_reg;
    iva_pkg::result_t  res_next;

    assign v_off  = {1'b0, item.vector} - WIN_LO;
    assign in_win = ({1'b0, item.vector} >= WIN_LO) && ({1'b0, item.vector} < WIN_HI);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= item.cmd;
            vec_reg    <= item.vector;
            hw_reg     <= item.handler_word;
            aw_reg     <= item.argument_word;
            in_win_reg <= in_win;
            slot_reg   <= in_win ? SLOT_W'(v_off) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_h_reg <= handler_mem[slot_reg];
        rd_a_reg <= argument_mem[slot_reg];
        if (mem_we)
        begin
            handler_mem[slot_reg]  <= hw_reg;
            argument_mem[slot_reg] <= aw_reg;
        end
    end

    assign free_pad   = (WIN > 0) ? PAD'(~alloc_map_reg) : '0;
    assign chunk_bits = free_pad[32 * chunk_reg +: 32];

    always_comb
    begin
        logic [PAD_W-1:0] idx;
        logic [PAD_W-1:0] hint_ext;
        hint_ext = PAD_W'(hint_reg);
        e1 = '0;
        e2 = '0;
        for (int k = 0; k < 32; k++)
        begin
            idx   = {chunk_reg, 5'(k)};
            m1[k] = chunk_bits[k] && (idx >= hint_ext);
            m2[k] = chunk_bits[k] && (idx < hint_ext);
        end
        low1 = m1 & (~m1 + 32'd1);
        low2 = m2 & (~m2 + 32'd1);
        for (int k = 0; k < 32; k++)
        begin
            if (low1[k])
            begin
                e1 = e1 | 5'(k);
            end
            if (low2[k])
            begin
                e2 = e2 | 5'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            i1_reg    <= '0;
            i2_reg    <= '0;
        end
        else if (ctl.load)
        begin
            chunk_reg <= '0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
        end
        else if (ctl.search_step)
        begin
            if (chunk_reg != LAST_CHUNK)
            begin
                chunk_reg <= chunk_reg + 1'b1;
            end
            if (!f1_reg && (m1 != '0))
            begin
                f1_reg <= 1'b1;
                i1_reg <= {chunk_reg, e1};
            end
            if (!f2_reg && (m2 != '0))
            begin
                f2_reg <= 1'b1;
                i2_reg <= {chunk_reg, e2};
            end
        end
    end

    always_comb
    begin
        logic [PAD_W-1:0]  gsel;
        logic [SLOT_W-1:0] g;
        logic [8:0]        gv;
        alloc_map_next        = alloc_map_reg;
        hnz_next              = hnz_reg;
        hint_next             = hint_reg;
        mem_we                = 1'b0;
        res_next.status       = iva_pkg::ST_OK;
        res_next.vector_out   = vec_reg;
        res_next.fire         = 1'b0;
        res_next.handler_out  = '0;
        res_next.argument_out = '0;
        gsel                  = f1_reg ? i1_reg : i2_reg;
        g                     = SLOT_W'(gsel);
        gv                    = 9'(gsel) + WIN_LO;
        if (cmd_reg == iva_pkg::CMD_ALLOC)
        begin
            if (f1_reg || f2_reg)
            begin
                alloc_map_next[g]   = 1'b1;
                hint_next           = g;
                res_next.vector_out = gv[7:0];
            end
            else
            begin
                res_next.status = iva_pkg::ST_NONE_FREE;
            end
        end
        else if (!in_win_reg)
        begin
            res_next.status = iva_pkg::ST_RANGE;
        end
        else
        begin
            case (cmd_reg)
                iva_pkg::CMD_CLAIM:
                begin
                    if (alloc_map_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_CLAIMED;
                    end
                    else
                    begin
                        alloc_map_next[slot_reg] = 1'b1;
                        hnz_next[slot_reg]       = 1'b0;
                    end
                end
                iva_pkg::CMD_FREE:
                begin
                    if (!alloc_map_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_DOUBLE_FREE;
                    end
                    alloc_map_next[slot_reg] = 1'b0;
                    hnz_next[slot_reg]       = 1'b0;
                end
                iva_pkg::CMD_ATTACH:
                begin
                    if (hw_reg == '0)
                    begin
                        res_next.status = iva_pkg::ST_NULL_HANDLER;
                    end
                    else if (!alloc_map_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_NOT_ALLOC;
                    end
                    else if (hnz_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_HANDLER_PRESENT;
                    end
                    else
                    begin
                        hnz_next[slot_reg] = 1'b1;
                        mem_we             = ctl.exec;
                    end
                end
                iva_pkg::CMD_DETACH:
                begin
                    if (!alloc_map_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_NOT_ALLOC;
                    end
                    else
                    begin
                        hnz_next[slot_reg] = 1'b0;
                    end
                end
                iva_pkg::CMD_DISPATCH:
                begin
                    if (!alloc_map_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_DISP_UNALLOC;
                    end
                    else if (!hnz_reg[slot_reg])
                    begin
                        res_next.status = iva_pkg::ST_DISP_NO_HANDLER;
                    end
                    else
                    begin
                        res_next.fire         = 1'b1;
                        res_next.handler_out  = rd_h_reg;
                        res_next.argument_out = rd_a_reg;
                    end
                end
                default:
                begin
                    res_next.status = iva_pkg::ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_map_reg <= '0;
            hnz_reg       <= '0;
            hint_reg      <= '0;
        end
        else if (ctl.exec)
        begin
            alloc_map_reg <= alloc_map_next;
            hnz_reg       <= hnz_next;
            hint_reg      <= hint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            res_reg <= res_next;
        end
    end

    assign res             = res_reg;
    assign sts.is_alloc    = (cmd_reg == iva_pkg::CMD_ALLOC);
    assign sts.search_last = (chunk_reg == LAST_CHUNK);

endmodule

`default_nettype wire
